// ===== rtl/m3drs_pkg.sv =====
// ----------------------------------------------------------------------------
// m3drs_pkg
// Shared types, constants and helpers for the 3D mesh adaptive route select.
// ----------------------------------------------------------------------------
`default_nettype none

package m3drs_pkg;

  // Mesh and field geometry
  localparam int MeshSize = 8;
  localparam int NumDims  = 3;
  localparam int NumPorts = 2 * NumDims;
  localparam int CoordW   = 3;
  localparam int PortW    = 3;
  localparam int CreditW  = 8;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = 1;

  // Reset values of the configuration registers
  localparam logic [CreditW-1:0] MsgLenReset   = 8'd4;
  localparam logic [CreditW-1:0] BufDepthReset = 8'd16;

  // Operation codes of an input item
  typedef enum logic [OpW-1:0] {
    OP_ROUTE  = 2'd0,
    OP_CREDIT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_X   = 3'd0,
    CFG_NODE_Y   = 3'd1,
    CFG_NODE_Z   = 3'd2,
    CFG_MSG_LEN  = 3'd3,
    CFG_BUF_DEPTH = 3'd4
  } cfg_idx_e;

  // Return channel codes
  localparam logic ChanR1 = 1'b0;
  localparam logic ChanR2 = 1'b1;

  // Configuration seen by the front and back parts
  typedef struct packed {
    logic [CoordW-1:0]  node_x;
    logic [CoordW-1:0]  node_y;
    logic [CoordW-1:0]  node_z;
    logic [CreditW-1:0] msg_len;
    logic [CreditW-1:0] buf_depth;
  } cfg_t;

  // Classified item travelling from front to back
  typedef struct packed {
    op_e                op;
    logic [NumDims-1:0] want;      // nonzero distance in that dimension
    logic [NumDims-1:0] dir;       // 1 toward the plus port
    logic [PortW-1:0]   ret_port;
    logic               ret_chan;
    logic [CreditW-1:0] ret_amt;
  } item_t;

  // Result of one item
  typedef struct packed {
    logic             granted;
    logic [PortW-1:0] port;
    logic             channel;
  } result_t;

  // Saturate a coordinate to the mesh edge
  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] c);
    logic [CoordW-1:0] r;
    r = c;
    if (int'(c) > MeshSize - 1) begin
      r = CoordW'(MeshSize - 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/m3drs_front.sv =====
// ----------------------------------------------------------------------------
// m3drs_front
// Accepts input items, classifies them against the node coordinates and
// holds them in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module m3drs_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire m3drs_pkg::cfg_t              cfg_i,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic [m3drs_pkg::OpW-1:0]    operation_i,
  input  wire logic [m3drs_pkg::CoordW-1:0] dst_x_i,
  input  wire logic [m3drs_pkg::CoordW-1:0] dst_y_i,
  input  wire logic [m3drs_pkg::CoordW-1:0] dst_z_i,
  input  wire logic [m3drs_pkg::PortW-1:0]  return_port_i,
  input  wire logic                         return_channel_i,
  input  wire logic [m3drs_pkg::CreditW-1:0] return_amount_i,
  output logic                              item_valid_o,
  output m3drs_pkg::item_t                  item_o,
  input  wire logic                         item_take_i
);
  import m3drs_pkg::*;

  item_t                 cls_item;
  logic [CoordW-1:0]     here [NumDims];
  logic [CoordW-1:0]     there [NumDims];
  item_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]    count_q, count_d;
  logic                  push_fire;
  logic                  pop_fire;

  // Classify: per dimension, is there a distance and which way
  always_comb begin
    here[0]  = clamp_coord(cfg_i.node_x);
    here[1]  = clamp_coord(cfg_i.node_y);
    here[2]  = clamp_coord(cfg_i.node_z);
    there[0] = clamp_coord(dst_x_i);
    there[1] = clamp_coord(dst_y_i);
    there[2] = clamp_coord(dst_z_i);
    cls_item          = '0;
    cls_item.op       = op_e'(operation_i);
    cls_item.ret_port = return_port_i;
    cls_item.ret_chan = return_channel_i;
    cls_item.ret_amt  = return_amount_i;
    for (int d = 0; d < NumDims; d++) begin
      cls_item.want[d] = (here[d] != there[d]);
      cls_item.dir[d]  = (there[d] > here[d]);
    end
  end

  assign full_o       = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = entry_q[rd_ptr_q];
  assign push_fire    = push_i && !full_o;
  assign pop_fire     = item_take_i && item_valid_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_fire ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_fire ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_fire && !pop_fire) begin
      count_d = count_q + 1'b1;
    end else if (!push_fire && pop_fire) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Hold classified items
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      entry_q[wr_ptr_q] <= cls_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/m3drs_back.sv =====
// ----------------------------------------------------------------------------
// m3drs_back
// Holds credits and used marks, routes one queued item per cycle while the
// output register is free or being drained, and keeps the result in it.
// ----------------------------------------------------------------------------
`default_nettype none

module m3drs_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire m3drs_pkg::cfg_t      cfg_i,
  input  wire logic                 item_valid_i,
  input  wire m3drs_pkg::item_t     item_i,
  output logic                      item_take_o,
  output logic                      res_valid_o,
  output m3drs_pkg::result_t        res_o,
  input  wire logic                 res_pop_i
);
  import m3drs_pkg::*;

  logic [CreditW-1:0] credit1_q [NumPorts];
  logic [CreditW-1:0] credit2_q [NumPorts];
  logic [NumPorts-1:0] used_q;
  logic               out_valid_q, out_valid_d;
  result_t            out_q;

  logic [PortW-1:0]   cand_port [NumDims];
  logic [NumDims-1:0] cand;
  logic [CreditW:0]   cand_sum [NumDims];
  logic               best_vld;
  logic [PortW-1:0]   best_port;
  logic [CreditW:0]   best_sum;
  logic               fire;
  logic               grant;
  logic               ret_ok;
  logic [CreditW-1:0] ret_old;
  logic [CreditW:0]   ret_sum;
  logic [CreditW-1:0] ret_new;
  result_t            res_d;

  // Take an item when the output register is free or being drained
  assign fire        = item_valid_i && (!out_valid_q || res_pop_i);
  assign item_take_o = fire;

  // Candidates per dimension
  always_comb begin
    for (int d = 0; d < NumDims; d++) begin
      cand_port[d] = PortW'(2 * d + int'(item_i.dir[d]));
      cand[d]      = item_i.want[d] && !used_q[cand_port[d]] &&
                     (credit1_q[cand_port[d]] >= cfg_i.msg_len);
      cand_sum[d]  = {1'b0, credit1_q[cand_port[d]]} + {1'b0, credit2_q[cand_port[d]]};
    end
  end

  // Pick the largest credit sum, earlier dimension on a tie
  always_comb begin
    best_vld  = 1'b0;
    best_port = '0;
    best_sum  = '0;
    for (int d = 0; d < NumDims; d++) begin
      if (cand[d] && (!best_vld || cand_sum[d] > best_sum)) begin
        best_vld  = 1'b1;
        best_port = cand_port[d];
        best_sum  = cand_sum[d];
      end
    end
  end

  assign grant = (item_i.op == OP_ROUTE) && best_vld;

  // Credit return with saturation at the buffer depth
  always_comb begin
    ret_ok  = (int'(item_i.ret_port) < NumPorts);
    ret_old = (item_i.ret_chan == ChanR2) ? credit2_q[item_i.ret_port]
                                          : credit1_q[item_i.ret_port];
    ret_sum = {1'b0, ret_old} + {1'b0, item_i.ret_amt};
    ret_new = (ret_sum > {1'b0, cfg_i.buf_depth}) ? cfg_i.buf_depth
                                                  : ret_sum[CreditW-1:0];
  end

  // Update credits and used marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPorts; p++) begin
        credit1_q[p] <= BufDepthReset;
        credit2_q[p] <= BufDepthReset;
      end
      used_q <= '0;
    end else if (fire) begin
      unique case (item_i.op)
        OP_ROUTE: begin
          if (best_vld) begin
            credit1_q[best_port] <= credit1_q[best_port] - cfg_i.msg_len;
            used_q[best_port]    <= 1'b1;
          end
        end
        OP_CREDIT: begin
          if (ret_ok) begin
            if (item_i.ret_chan == ChanR2) begin
              credit2_q[item_i.ret_port] <= ret_new;
            end else begin
              credit1_q[item_i.ret_port] <= ret_new;
            end
          end
        end
        OP_CLEAR: begin
          used_q <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Form the result
  always_comb begin
    res_d         = '0;
    res_d.granted = grant;
    res_d.port    = grant ? best_port : '0;
    res_d.channel = ChanR1;
  end

  // Hold the result until it is popped
  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (res_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // A granted port was unused and had enough R1 credit
  a_grant_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && grant |-> !used_q[best_port] && credit1_q[best_port] >= cfg_i.msg_len)
    else $error("grant on a used or short port");

  // A grant marks its port used on the next cycle
  a_grant_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && grant |=> used_q[$past(best_port)])
    else $error("granted port not marked used");

  // A shown grant names an existing port
  a_port_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.granted |-> int'(out_q.port) < NumPorts)
    else $error("granted port out of range");

  // A clear leaves no port used
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_i.op == OP_CLEAR |=> used_q == '0)
    else $error("used marks not cleared");

endmodule

`default_nettype wire

// ===== rtl/mesh3d_adaptive_route_select.sv =====
// ----------------------------------------------------------------------------
// mesh3d_adaptive_route_select
// Minimal adaptive output selection for one router of a 3D mesh.
// ----------------------------------------------------------------------------
// Items enter through a queue-style port (push/full) and results leave the
// same way (empty/pop); every accepted item gives exactly one result, in
// order. The block sustains one item per clock when nothing stalls: the
// front classifies an item into a two-entry queue on the cycle it is
// accepted, and the back takes one queued item per cycle while its output
// register is free or being popped, updating credits and used marks and
// registering the result; an item passes the queue entry, then the output
// register. The credit and used-mark update in the back sets that rate.
// Configuration writes are taken at once (cfg_ready_o is always high) and
// must only be made while the block is idle.
`default_nettype none

module mesh3d_adaptive_route_select (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write channel
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [m3drs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [m3drs_pkg::CfgDataW-1:0] cfg_data_i,
  // input items
  input  wire logic                           push_i,
  output logic                                full_o,
  input  wire logic [m3drs_pkg::OpW-1:0]      operation_i,
  input  wire logic [m3drs_pkg::CoordW-1:0]   dst_x_i,
  input  wire logic [m3drs_pkg::CoordW-1:0]   dst_y_i,
  input  wire logic [m3drs_pkg::CoordW-1:0]   dst_z_i,
  input  wire logic [m3drs_pkg::PortW-1:0]    return_port_i,
  input  wire logic                           return_channel_i,
  input  wire logic [m3drs_pkg::CreditW-1:0]  return_amount_i,
  // results
  output logic                                empty_o,
  input  wire logic                           pop_i,
  output logic                                granted_o,
  output logic [m3drs_pkg::PortW-1:0]         out_port_o,
  output logic                                out_channel_o
);
  import m3drs_pkg::*;

  cfg_t    cfg_q;
  logic    cfg_fire;
  logic    item_valid;
  item_t   item;
  logic    item_take;
  logic    res_valid;
  result_t res;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_x    <= '0;
      cfg_q.node_y    <= '0;
      cfg_q.node_z    <= '0;
      cfg_q.msg_len   <= MsgLenReset;
      cfg_q.buf_depth <= BufDepthReset;
    end else if (cfg_fire) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_NODE_X:    cfg_q.node_x    <= cfg_data_i[CoordW-1:0];
        CFG_NODE_Y:    cfg_q.node_y    <= cfg_data_i[CoordW-1:0];
        CFG_NODE_Z:    cfg_q.node_z    <= cfg_data_i[CoordW-1:0];
        CFG_MSG_LEN:   cfg_q.msg_len   <= cfg_data_i[CreditW-1:0];
        CFG_BUF_DEPTH: cfg_q.buf_depth <= cfg_data_i[CreditW-1:0];
        default: begin
        end
      endcase
    end
  end

  m3drs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .push_i           (push_i),
    .full_o           (full_o),
    .operation_i      (operation_i),
    .dst_x_i          (dst_x_i),
    .dst_y_i          (dst_y_i),
    .dst_z_i          (dst_z_i),
    .return_port_i    (return_port_i),
    .return_channel_i (return_channel_i),
    .return_amount_i  (return_amount_i),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_take_i      (item_take)
  );

  m3drs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop_i)
  );

  assign empty_o       = !res_valid;
  assign granted_o     = res.granted;
  assign out_port_o    = res.port;
  assign out_channel_o = res.channel;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3D mesh adaptive route select.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first, then several random phases,
// each with its own register settings and an idling pattern on the push
// and pop sides. A local predictor tracks credits, used marks and the node
// registers; every accepted item queues one expected result, and every popped
// result is compared with the oldest one, field by field.
module testbench;
  import m3drs_pkg::*;

  localparam int HoldCycles    = 200;
  localparam int WatchdogLimit = 3000;
  localparam int PhaseItems    = 70;
  localparam int NumDirected   = 18;

  // Output port codes
  localparam logic [PortW-1:0] PortXMinus = 3'd0;
  localparam logic [PortW-1:0] PortXPlus  = 3'd1;
  localparam logic [PortW-1:0] PortYMinus = 3'd2;
  localparam logic [PortW-1:0] PortYPlus  = 3'd3;
  localparam logic [PortW-1:0] PortZMinus = 3'd4;
  localparam logic [PortW-1:0] PortZPlus  = 3'd5;
  localparam logic [PortW-1:0] PortSpareA = 3'd6;
  localparam logic [PortW-1:0] PortSpareB = 3'd7;

  typedef struct packed {
    op_e                op;
    logic [CoordW-1:0]  dst_x;
    logic [CoordW-1:0]  dst_y;
    logic [CoordW-1:0]  dst_z;
    logic [PortW-1:0]   ret_port;
    logic               ret_chan;
    logic [CreditW-1:0] ret_amt;
  } route_req_t;

  typedef struct packed {
    route_req_t req;
    logic       typed;
    result_t    outcome;
  } directed_row_t;

  // Clock, reset and block inputs
  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;
  logic                push_i           = 1'b0;
  logic [OpW-1:0]      operation_i      = '0;
  logic [CoordW-1:0]   dst_x_i          = '0;
  logic [CoordW-1:0]   dst_y_i          = '0;
  logic [CoordW-1:0]   dst_z_i          = '0;
  logic [PortW-1:0]    return_port_i    = '0;
  logic                return_channel_i = 1'b0;
  logic [CreditW-1:0]  return_amount_i  = '0;
  logic                pop_i            = 1'b0;
  logic                cfg_ready_o;
  logic                full_o;
  logic                empty_o;
  logic                granted_o;
  logic [PortW-1:0]    out_port_o;
  logic                out_channel_o;

  // Typed-in expectation travelling with the pushed item
  logic    row_typed   = 1'b0;
  result_t row_outcome = '0;

  // Predictor state and registers
  logic [CoordW-1:0]  node_x, node_y, node_z;
  logic [CreditW-1:0] msg_len, buf_depth;
  logic [CreditW-1:0] credit_r1 [NumPorts];
  logic [CreditW-1:0] credit_r2 [NumPorts];
  logic [NumPorts-1:0] port_used;

  result_t pending_results [$];
  int      failures       = 0;
  int      idle_cycles    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  int      hold_ticket    = 0;
  int      hold_served    = 0;
  int      hold_left      = 0;

  // Directed requests, starting from reset settings: node at the origin,
  // message length 4, buffer depth 16
  directed_row_t directed_rows [NumDirected] = '{
    // destination equals this node
    '{'{OP_ROUTE, 3'd0, 3'd0, 3'd0, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    // all three plus ports tie, x first, then y, then z
    '{'{OP_ROUTE, 3'd7, 3'd7, 3'd7, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b1, PortXPlus, ChanR1}},
    '{'{OP_ROUTE, 3'd7, 3'd7, 3'd7, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b1, PortYPlus, ChanR1}},
    '{'{OP_ROUTE, 3'd7, 3'd7, 3'd7, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b1, PortZPlus, ChanR1}},
    // every candidate already used
    '{'{OP_ROUTE, 3'd7, 3'd7, 3'd7, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    '{'{OP_CLEAR, 3'd0, 3'd0, 3'd0, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    // refill saturates at buffer depth
    '{'{OP_CREDIT, 3'd0, 3'd0, 3'd0, PortXPlus, ChanR1, 8'd255}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    // return to a nonexistent port is dropped
    '{'{OP_CREDIT, 3'd7, 3'd7, 3'd7, PortSpareB, ChanR2, 8'd255}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    // unused operation code with every field bit set
    '{'{OP_NONE, 3'd7, 3'd7, 3'd7, PortSpareB, ChanR2, 8'd255}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    '{'{OP_CREDIT, 3'd0, 3'd0, 3'd0, PortYPlus, ChanR2, 8'd0}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    '{'{OP_ROUTE, 3'd7, 3'd0, 3'd0, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b1, PortXPlus, ChanR1}},
    '{'{OP_ROUTE, 3'd0, 3'd7, 3'd7, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b1, PortYPlus, ChanR1}},
    '{'{OP_ROUTE, 3'd0, 3'd0, 3'd7, PortXMinus, ChanR1, 8'd0}, 1'b1,
      '{1'b1, PortZPlus, ChanR1}},
    '{'{OP_CREDIT, 3'd0, 3'd0, 3'd0, PortSpareA, ChanR1, 8'd128}, 1'b1,
      '{1'b0, PortXMinus, ChanR1}},
    '{'{OP_CREDIT, 3'd0, 3'd0, 3'd0, PortZPlus, ChanR2, 8'd1}, 1'b0, '0},
    '{'{OP_CLEAR, 3'd5, 3'd2, 3'd6, PortZMinus, ChanR2, 8'd77}, 1'b0, '0},
    '{'{OP_ROUTE, 3'd3, 3'd5, 3'd6, PortYMinus, ChanR1, 8'd0}, 1'b0, '0},
    '{'{OP_CREDIT, 3'd0, 3'd0, 3'd0, PortXMinus, ChanR1, 8'd200}, 1'b0, '0}
  };

  mesh3d_adaptive_route_select dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push_i           (push_i),
    .full_o           (full_o),
    .operation_i      (operation_i),
    .dst_x_i          (dst_x_i),
    .dst_y_i          (dst_y_i),
    .dst_z_i          (dst_z_i),
    .return_port_i    (return_port_i),
    .return_channel_i (return_channel_i),
    .return_amount_i  (return_amount_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .granted_o        (granted_o),
    .out_port_o       (out_port_o),
    .out_channel_o    (out_channel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one item to the local state and return the result it yields.
  // Coordinates cannot exceed the mesh edge at this width, so no clamp.
  function automatic result_t select_output(input route_req_t req);
    result_t            res;
    logic [CoordW-1:0]  here [NumDims];
    logic [CoordW-1:0]  there [NumDims];
    logic               found;
    logic [PortW-1:0]   best;
    logic [CreditW:0]   best_sum;
    logic [CreditW:0]   sum;
    logic [CreditW:0]   level;
    int                 d;
    int                 p;
    res      = '0;
    found    = 1'b0;
    best     = '0;
    best_sum = '0;
    here     = '{node_x, node_y, node_z};
    there    = '{req.dst_x, req.dst_y, req.dst_z};
    case (req.op)
      OP_ROUTE: begin
        for (d = 0; d < NumDims; d++) begin
          if (here[d] != there[d]) begin
            p = 2 * d + ((there[d] > here[d]) ? 1 : 0);
            if (!port_used[p] && credit_r1[p] >= msg_len) begin
              sum = {1'b0, credit_r1[p]} + {1'b0, credit_r2[p]};
              if (!found || sum > best_sum) begin
                found    = 1'b1;
                best     = PortW'(p);
                best_sum = sum;
              end
            end
          end
        end
        // consume credits on the winner and mark it used
        if (found) begin
          credit_r1[best] = credit_r1[best] - msg_len;
          port_used[best] = 1'b1;
          res.granted     = 1'b1;
          res.port        = best;
          res.channel     = ChanR1;
        end
      end
      OP_CREDIT: begin
        if (req.ret_port < NumPorts) begin
          level = (req.ret_chan == ChanR2) ? {1'b0, credit_r2[req.ret_port]}
                                           : {1'b0, credit_r1[req.ret_port]};
          level = level + {1'b0, req.ret_amt};
          if (level > {1'b0, buf_depth}) begin
            level = {1'b0, buf_depth};
          end
          if (req.ret_chan == ChanR2) begin
            credit_r2[req.ret_port] = level[CreditW-1:0];
          end else begin
            credit_r1[req.ret_port] = level[CreditW-1:0];
          end
        end
      end
      OP_CLEAR: begin
        port_used = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Route requests with random content half the time, plus refills, clears and noise
  function automatic route_req_t random_request();
    route_req_t req;
    int         pick;
    req.op       = OP_NONE;
    req.dst_x    = CoordW'($urandom_range(7));
    req.dst_y    = CoordW'($urandom_range(7));
    req.dst_z    = CoordW'($urandom_range(7));
    req.ret_port = PortW'($urandom_range(NumPorts - 1));
    req.ret_chan = 1'($urandom_range(1));
    req.ret_amt  = CreditW'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 50) begin
      req.op = OP_ROUTE;
      if ($urandom_range(9) == 0) begin
        req.dst_x = node_x;
        req.dst_y = node_y;
        req.dst_z = node_z;
      end
    end else if (pick < 78) begin
      req.op = OP_CREDIT;
      if ($urandom_range(9) == 0) begin
        req.ret_port = PortW'($urandom_range(7, NumPorts));
      end
      case ($urandom_range(3))
        0: req.ret_amt = 8'd0;
        1: req.ret_amt = 8'd255;
        2: req.ret_amt = CreditW'($urandom_range(8));
        default: begin
        end
      endcase
    end else if (pick < 95) begin
      req.op = OP_CLEAR;
    end
    return req;
  endfunction

  // Offer one item, idling first at the current rate, until it transfers
  task automatic send_item(input route_req_t req, input logic typed,
                           input result_t outcome);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i           <= 1'b1;
    operation_i      <= req.op;
    dst_x_i          <= req.dst_x;
    dst_y_i          <= req.dst_y;
    dst_z_i          <= req.dst_z;
    return_port_i    <= req.ret_port;
    return_channel_i <= req.ret_chan;
    return_amount_i  <= req.ret_amt;
    row_typed        <= typed;
    row_outcome      <= outcome;
    @(posedge clk_i);
    while (full_o) begin
      @(posedge clk_i);
    end
  endtask

  // Stop offering and hold until every expected result has been popped
  task automatic drain_results();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      CFG_NODE_X:    node_x    = data[CoordW-1:0];
      CFG_NODE_Y:    node_y    = data[CoordW-1:0];
      CFG_NODE_Z:    node_z    = data[CoordW-1:0];
      CFG_MSG_LEN:   msg_len   = data;
      CFG_BUF_DEPTH: buf_depth = data;
      default: begin
      end
    endcase
  endtask

  task automatic load_settings(input int nx, input int ny, input int nz,
                               input int ml, input int bd);
    write_register(CFG_NODE_X, CfgDataW'(nx));
    write_register(CFG_NODE_Y, CfgDataW'(ny));
    write_register(CFG_NODE_Z, CfgDataW'(nz));
    write_register(CFG_MSG_LEN, CfgDataW'(ml));
    write_register(CFG_BUF_DEPTH, CfgDataW'(bd));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // One random phase at the given idle rates; squeeze asks for a long hold-off
  task automatic run_phase(input int send_pct, input int recv_pct, input bit squeeze);
    int k;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (squeeze) begin
      hold_ticket++;
    end
    for (k = 0; k < PhaseItems; k++) begin
      send_item(random_request(), 1'b0, '0);
    end
    drain_results();
  endtask

  // Pop side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop_i <= 1'b0;
    end else if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      hold_left   = HoldCycles;
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on each item transfer, check each result transfer, watch for hangs
  always @(posedge clk_i) begin
    result_t    want;
    route_req_t seen_req;
    logic       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (push_i && !full_o) begin
        seen_req = '{op_e'(operation_i), dst_x_i, dst_y_i, dst_z_i,
                     return_port_i, return_channel_i, return_amount_i};
        want = select_output(seen_req);
        if (row_typed) begin
          want = row_outcome;
        end
        pending_results.push_back(want);
        moved = 1'b1;
      end
      if (pop_i && !empty_o) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (granted_o !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, granted_o);
            failures++;
          end
          if (out_port_o !== want.port) begin
            $error("out_port: expected %0d, got %0d", want.port, out_port_o);
            failures++;
          end
          if (out_channel_o !== want.channel) begin
            $error("out_channel: expected %0d, got %0d", want.channel, out_channel_o);
            failures++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int k;
    node_x    = '0;
    node_y    = '0;
    node_z    = '0;
    msg_len   = MsgLenReset;
    buf_depth = BufDepthReset;
    port_used = '0;
    for (k = 0; k < NumPorts; k++) begin
      credit_r1[k] = BufDepthReset;
      credit_r2[k] = BufDepthReset;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings
    for (k = 0; k < NumDirected; k++) begin
      send_item(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].outcome);
    end
    drain_results();

    // random phases, each with its own settings, at given idle rates
    load_settings($urandom_range(7), $urandom_range(7), $urandom_range(7), 255, 255);
    run_phase(0, 0, 1'b0);
    load_settings(7, 7, 7, 1, 1);
    run_phase(62, 0, 1'b0);
    load_settings(0, 7, 3, 0, 0);
    run_phase(0, 62, 1'b0);
    load_settings($urandom_range(7), $urandom_range(7), $urandom_range(7),
                  $urandom_range(6, 1), $urandom_range(40, 6));
    run_phase(11, 11, 1'b0);
    load_settings($urandom_range(7), $urandom_range(7), $urandom_range(7),
                  $urandom_range(4, 1), 24);
    run_phase(0, 0, 1'b1);
    load_settings(7, 0, 7, 8, 255);
    run_phase(30, 30, 1'b0);
    load_settings($urandom_range(7), $urandom_range(7), $urandom_range(7),
                  $urandom_range(8, 1), $urandom_range(255, 8));
    run_phase(0, 0, 1'b0);

    // let the pipeline settle, then report
    repeat (5) @(posedge clk_i);
    if (failures == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
